FILE: rtl/core/b64sc_pkg.sv
package b64sc_pkg;

	localparam int unsigned MAX_RESULTS = 4;

	localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

	// APB register map (byte addresses)
	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_DIRECTION = 3'd0;

	// direction register values
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
		logic       out_error;
	} result_t;

	typedef struct packed {
		logic [15:0] group_bytes;
		logic [1:0]  group_count;
		logic [5:0]  bit_accumulator;
		logic [2:0]  bit_count;
		logic        stopped;
		logic        error_seen;
	} msg_state_t;

	typedef struct packed {
		logic [2:0] count;
		result_t    res0;
		result_t    res1;
		result_t    res2;
		result_t    res3;
	} step_out_t;

	// 6-bit value to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

	// character to {in_alphabet, 6-bit value}
	function automatic logic [6:0] dec_value(input logic [7:0] c);
		logic [6:0] r;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2B) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b1, 6'd63};
		end else begin
			r = 7'd0;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/base64_stream_codec.sv
// Base64 stream codec, standard alphabet with '=' padding, one byte per request.
// A request is held in the input register; its results load into the result buffer
// when it advances, and the first of them is then offered on the result channel.
// Throughput: one request per cycle; a request that yields results waits while the
// buffer drains (four results per encode group of three bytes, one per decoded byte).
// Reset (arst_n low, asynchronous) clears direction to encode and all message state.
module base64_stream_codec (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        out_last,
	output logic        out_error
);
	import b64sc_pkg::*;

	logic        direction_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eom_s1;

	// message state
	msg_state_t  state_q;
	msg_state_t  state_nxt;
	step_out_t   step;

	// result buffer: up to four results from one request
	result_t     buf_q [MAX_RESULTS];
	logic [2:0]  cnt_q;
	logic [1:0]  rd_q;

	logic        in_accept;
	logic        res_accept;
	logic        buf_free;
	logic        advance;

	assign pready = 1'b1;

	// register file: only the direction bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_DIRECTION) begin
			direction_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == ADDR_DIRECTION) ? {31'd0, direction_q} : 32'd0;

	b64sc_step u_step (
		.direction      (direction_q),
		.data_byte      (byte_s1),
		.end_of_message (eom_s1),
		.cur            (state_q),
		.nxt            (state_nxt),
		.res            (step)
	);

	// The buffer can take new results when it is empty or its last entry
	// leaves this cycle. A request that yields no results never waits.
	assign res_valid  = (cnt_q != 3'd0);
	assign res_accept = res_valid && !res_stall;
	assign buf_free   = (cnt_q == 3'd0) || (cnt_q == 3'd1 && res_accept);
	assign advance    = valid_s1 && (step.count == 3'd0 || buf_free);

	// Stall only while a held request cannot advance.
	assign in_stall   = valid_s1 && !advance;
	assign in_accept  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (!valid_s1 || advance) begin
				valid_s1 <= in_accept;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	// payload of the input register needs no reset
	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= data_byte;
			eom_s1  <= end_of_message;
		end
	end

	// Load a fresh batch of results, or advance the read pointer on each
	// taken result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			rd_q  <= 2'd0;
		end else if (advance && step.count != 3'd0) begin
			cnt_q <= step.count;
			rd_q  <= 2'd0;
		end else if (res_accept) begin
			cnt_q <= cnt_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.count != 3'd0) begin
			buf_q[0] <= step.res0;
			buf_q[1] <= step.res1;
			buf_q[2] <= step.res2;
			buf_q[3] <= step.res3;
		end
	end

	assign out_byte  = buf_q[rd_q].out_byte;
	assign out_valid = buf_q[rd_q].out_valid;
	assign out_last  = buf_q[rd_q].out_last;
	assign out_error = buf_q[rd_q].out_error;

endmodule

FILE: rtl/core/b64sc_step.sv
module b64sc_step (
	input  logic                   direction,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_message,
	input  b64sc_pkg::msg_state_t  cur,
	output b64sc_pkg::msg_state_t  nxt,
	output b64sc_pkg::step_out_t   res
);
	import b64sc_pkg::*;

	logic [1:0]  n_grp;
	logic [23:0] frag;
	logic [6:0]  dv;
	logic [11:0] acc;
	logic [3:0]  bits;
	logic [3:0]  bits_left;
	logic [12:0] one_sh;
	logic [11:0] mask;
	logic [11:0] acc_sh;
	logic [11:0] acc_keep;

	always_comb begin
		n_grp = cur.group_count + 2'd1;
		unique case (n_grp)
			2'd1:    frag = {data_byte, 16'd0};
			2'd2:    frag = {cur.group_bytes[7:0], data_byte, 8'd0};
			default: frag = {cur.group_bytes, data_byte};
		endcase

		dv        = dec_value(data_byte);
		acc       = {cur.bit_accumulator, dv[5:0]};
		bits      = {1'b0, cur.bit_count} + 4'd6;
		bits_left = (bits >= 4'd8) ? bits - 4'd8 : bits;
		acc_sh    = acc >> bits_left;
		one_sh    = 13'd1 << bits_left;
		mask      = one_sh[11:0] - 12'd1;
		acc_keep  = acc & mask;
	end

	always_comb begin
		nxt = cur;
		res = '0;
		if (direction == DIR_ENCODE) begin
			if (n_grp < 2'd3 && !end_of_message) begin
				// hold the byte until the group fills
				nxt.group_bytes = {cur.group_bytes[7:0], data_byte};
				nxt.group_count = n_grp;
			end else begin
				res.count = 3'd4;
				res.res0  = '{enc_char(frag[23:18]), 1'b1, 1'b0, 1'b0};
				res.res1  = '{enc_char(frag[17:12]), 1'b1, 1'b0, 1'b0};
				res.res2  = '{(n_grp >= 2'd2) ? enc_char(frag[11:6]) : PAD_CHAR,
					1'b1, 1'b0, 1'b0};
				res.res3  = '{(n_grp == 2'd3) ? enc_char(frag[5:0]) : PAD_CHAR,
					1'b1, end_of_message, 1'b0};
				nxt.group_bytes = '0;
				nxt.group_count = '0;
			end
		end else begin
			if (!cur.stopped) begin
				if (data_byte == PAD_CHAR) begin
					nxt.stopped = 1'b1;
				end else if (!dv[6]) begin
					nxt.stopped    = 1'b1;
					nxt.error_seen = 1'b1;
				end else begin
					if (bits >= 4'd8) begin
						res.count = 3'd1;
						res.res0  = '{acc_sh[7:0], 1'b1, end_of_message, cur.error_seen};
					end
					nxt.bit_accumulator = acc_keep[5:0];
					nxt.bit_count       = bits_left[2:0];
				end
			end
			// empty end marker when the last character yields no byte
			if (end_of_message && res.count == 3'd0) begin
				res.count = 3'd1;
				res.res0  = '{8'd0, 1'b0, 1'b1, nxt.error_seen};
			end
		end
		if (end_of_message) begin
			nxt = '0;
		end
	end

endmodule
